@@ rtl/bcba_pkg.sv @@
`default_nettype none

package bcba_pkg;

   // Bitmap geometry
   localparam int MAP_BYTES_MAX   = 32;
   localparam int BLOCK_W         = 8;
   localparam int BITS_PER_BYTE   = 8;
   localparam int BIT_W           = 3;
   localparam int BYTE_W          = BLOCK_W - BIT_W;
   localparam int PTR_W           = BYTE_W + 1;
   localparam int COUNT_W         = 9;
   localparam int LIMIT_W         = BLOCK_W + 1;
   localparam int SUM_W           = BLOCK_W + 2;
   localparam int MB_W            = 6;
   localparam int MAP_IDX_W       = (MAP_BYTES_MAX > 1) ? $clog2(MAP_BYTES_MAX) : 1;
   localparam int ADDR_BYTES      = 1 << BYTE_W;
   localparam int BYTES_LIMIT     = (MAP_BYTES_MAX < ADDR_BYTES) ? MAP_BYTES_MAX : ADDR_BYTES;
   localparam logic [MB_W-1:0] MAP_BYTES_RESET = MB_W'(32);

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               cmd;
      logic [BLOCK_W-1:0] first_block;
      logic [COUNT_W-1:0] block_count;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [BLOCK_W-1:0] run_start;
   } rsp_type;

   // Bitmap byte access: read and optional masked set or clear at one address
   typedef struct packed {
      logic [BYTE_W-1:0]        addr;
      logic                     wr_en;
      logic                     set;
      logic [BITS_PER_BYTE-1:0] mask;
   } map_cmd_type;

   // Run finder operands and result
   typedef struct packed {
      logic [BYTE_W-1:0]  idx;
      logic [COUNT_W-1:0] run;
      logic [COUNT_W-1:0] count;
   } scan_req_type;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] run;
      logic [BLOCK_W-1:0] start;
   } scan_res_type;

   function automatic logic [MAP_IDX_W-1:0] to_map_idx(input logic [BYTE_W-1:0] ptr);
      return MAP_IDX_W'(ptr);
   endfunction

endpackage

`default_nettype wire

@@ rtl/bcba_map.sv @@
`default_nettype none

module bcba_map
   import bcba_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire map_cmd_type              map_cmd,
   output logic [BITS_PER_BYTE-1:0]      rd_data
);

   logic [BITS_PER_BYTE-1:0] map_ff [MAP_BYTES_MAX];
   logic [BITS_PER_BYTE-1:0] wr_data_in;
   logic [MAP_IDX_W-1:0]     idx;

   assign idx     = to_map_idx(map_cmd.addr);
   assign rd_data = map_ff[idx];

   // Merge the mask into the current byte
   always_comb begin
      if (map_cmd.set) begin
         wr_data_in = rd_data | map_cmd.mask;
      end else begin
         wr_data_in = rd_data & ~map_cmd.mask;
      end
   end

   // Hold the bitmap, all blocks free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_BYTES_MAX; i++) begin
            map_ff[i] <= '0;
         end
      end else if (map_cmd.wr_en) begin
         map_ff[idx] <= wr_data_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bcba_scan.sv @@
`default_nettype none

module bcba_scan
   import bcba_pkg::*;
(
   input  wire scan_req_type             scan_req,
   input  wire logic [BITS_PER_BYTE-1:0] map_byte,
   output scan_res_type                  scan_res
);

   // Walk the eight blocks of one byte, carrying the free run length
   always_comb begin
      logic [COUNT_W-1:0] run;
      logic               found;
      logic [BLOCK_W-1:0] start;
      logic [BLOCK_W-1:0] blk;
      run   = scan_req.run;
      found = 1'b0;
      start = '0;
      blk   = '0;
      for (int i = 0; i < BITS_PER_BYTE; i++) begin
         blk = {scan_req.idx, BIT_W'(i)};
         if (!found) begin
            if (map_byte[i]) begin
               run = '0;
            end else begin
               run = run + COUNT_W'(1);
               if (run == scan_req.count) begin
                  found = 1'b1;
                  start = BLOCK_W'(COUNT_W'(blk) + COUNT_W'(1) - scan_req.count);
               end
            end
         end
      end
      scan_res.found = found;
      scan_res.run   = run;
      scan_res.start = start;
   end

endmodule

`default_nettype wire

@@ rtl/bcba_ctrl.sv @@
`default_nettype none

module bcba_ctrl
   import bcba_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire req_type                  req_data,
   input  wire logic [MB_W-1:0]          map_bytes,
   output map_cmd_type                   map_cmd,
   output scan_req_type                  scan_req,
   input  wire scan_res_type             scan_res,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data
);

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [COUNT_W-1:0] run_ff, run_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BLOCK_W-1:0] lo_ff, lo_in;
   logic [BLOCK_W-1:0] hi_ff, hi_in;
   logic               set_ff, set_in;
   logic               ok_ff, ok_in;
   logic [BLOCK_W-1:0] start_ff, start_in;

   logic [PTR_W-1:0]   nbytes;
   logic [LIMIT_W-1:0] limit;
   logic [SUM_W-1:0]   free_end;
   logic [SUM_W-1:0]   limit_ext;
   logic               free_in_range;
   logic               free_fits;
   logic               scan_done;
   logic               mark_last;
   logic [BITS_PER_BYTE-1:0] mark_mask;

   // Clamp the map size and derive the block limit
   assign nbytes    = (map_bytes > MB_W'(BYTES_LIMIT)) ? PTR_W'(BYTES_LIMIT) : PTR_W'(map_bytes);
   assign limit     = {nbytes, BIT_W'(0)};
   assign limit_ext = SUM_W'(limit);
   assign free_end  = SUM_W'(req_data.first_block) + SUM_W'(req_data.block_count) - SUM_W'(1);
   assign free_in_range = SUM_W'(req_data.first_block) < limit_ext;
   assign free_fits = free_end < limit_ext;
   assign scan_done = (ptr_ff == nbytes);
   assign mark_last = (ptr_ff[BYTE_W-1:0] == hi_ff[BLOCK_W-1:BIT_W]);

   assign scan_req.idx   = ptr_ff[BYTE_W-1:0];
   assign scan_req.run   = run_ff;
   assign scan_req.count = count_ff;

   // Select the bits of the current byte that lie inside the run
   always_comb begin
      logic [BLOCK_W-1:0] blk;
      blk = '0;
      for (int j = 0; j < BITS_PER_BYTE; j++) begin
         blk = {ptr_ff[BYTE_W-1:0], BIT_W'(j)};
         mark_mask[j] = (blk >= lo_ff) && (blk <= hi_ff);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req_data.block_count == '0) begin
                  state_in = ST_RESP;
               end else if (req_data.cmd == CMD_ALLOC) begin
                  state_in = ST_SCAN;
               end else if (free_in_range) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            priority if (scan_done) begin
               state_in = ST_RESP;
            end else if (scan_res.found) begin
               state_in = ST_MARK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MARK: begin
            if (mark_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      map_cmd.addr = ptr_ff[BYTE_W-1:0];
      map_cmd.wr_en = 1'b0;
      map_cmd.set  = set_ff;
      map_cmd.mask = mark_mask;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SCAN: begin
         end
         ST_MARK: begin
            map_cmd.wr_en = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign rsp_data.ok        = ok_ff;
   assign rsp_data.run_start = start_ff;

   // Datapath next values
   always_comb begin
      ptr_in   = ptr_ff;
      run_in   = run_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      set_in   = set_ff;
      ok_in    = ok_ff;
      start_in = start_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               count_in = req_data.block_count;
               run_in   = '0;
               ok_in    = 1'b0;
               start_in = '0;
               set_in   = (req_data.cmd == CMD_ALLOC);
               if (req_data.cmd == CMD_ALLOC) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = PTR_W'(req_data.first_block[BLOCK_W-1:BIT_W]);
                  lo_in  = req_data.first_block;
                  hi_in  = free_fits ? free_end[BLOCK_W-1:0]
                                     : BLOCK_W'(limit - LIMIT_W'(1));
                  ok_in  = free_fits && (req_data.block_count != '0);
               end
            end
         end
         ST_SCAN: begin
            ptr_in = ptr_ff + PTR_W'(1);
            run_in = scan_res.run;
            if (!scan_done && scan_res.found) begin
               ptr_in   = PTR_W'(scan_res.start[BLOCK_W-1:BIT_W]);
               lo_in    = scan_res.start;
               hi_in    = BLOCK_W'(COUNT_W'(scan_res.start) + count_ff - COUNT_W'(1));
               ok_in    = 1'b1;
               start_in = scan_res.start;
            end
         end
         ST_MARK: begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ok_ff    <= 1'b0;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
         start_ff <= start_in;
      end
   end

   // Hold working registers
   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      run_ff   <= run_in;
      count_ff <= count_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      set_ff   <= set_in;
   end

endmodule

`default_nettype wire

@@ rtl/bitmap_contiguous_block_allocator_unit.sv @@
// First-fit contiguous block allocator over a 256-block bitmap (1 = used).
// A request is taken when start is high and busy is low; busy then stays
// high until the single response, which appears on rsp_data for exactly one
// cycle with rsp_valid high and cannot be stalled, so the receiver must take
// it then. An allocate scans one bitmap byte per cycle through a single
// eight-bit run finder, then sets one byte of the run per cycle. One that
// finds no run scans every byte in use and responds with ok low. A free
// clears the bytes of its range, and a request with a zero count or a free
// that starts beyond the map goes straight to its response.
// Blocks of a free that lie beyond the map are skipped and flagged with ok
// low. The map-size register (csr_wdata, default 32 bytes) is always ready
// and must be written only while busy is low. The bitmap clears to all free
// on reset, with no sweep.
`default_nettype none

module bitmap_contiguous_block_allocator_unit
   import bcba_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire req_type         req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [MB_W-1:0] csr_wdata
);

   logic [MB_W-1:0]          map_bytes_ff, map_bytes_in;
   map_cmd_type              map_cmd;
   logic [BITS_PER_BYTE-1:0] map_rd_data;
   scan_req_type             scan_req;
   scan_res_type             scan_res;

   assign csr_ready    = 1'b1;
   assign map_bytes_in = (csr_valid && csr_ready) ? csr_wdata : map_bytes_ff;

   // Hold the map size register
   always_ff @(posedge clock) begin
      if (reset) begin
         map_bytes_ff <= MAP_BYTES_RESET;
      end else begin
         map_bytes_ff <= map_bytes_in;
      end
   end

   bcba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_cmd (map_cmd),
      .rd_data (map_rd_data)
   );

   bcba_scan u_scan (
      .scan_req (scan_req),
      .map_byte (map_rd_data),
      .scan_res (scan_res)
   );

   bcba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .map_bytes (map_bytes_ff),
      .map_cmd   (map_cmd),
      .scan_req  (scan_req),
      .scan_res  (scan_res),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/bcba_checker.sv @@
`default_nettype none

module bcba_checker
   import bcba_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // An accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A response only appears while a request is in flight
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response without a request in flight");

   // A response is a single-cycle strobe that releases the block
   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response did not end the request");

   // A failed request reports start block zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.run_start == '0))
      else $error("failed request reported a nonzero start");

endmodule

bind bitmap_contiguous_block_allocator_unit bcba_checker u_bcba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
